// ----- hdl/chs_lba_address_translator_unit_assert.svh -----
// Assertion macros for the address translator.
`ifndef CHS_LBA_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH
`define CHS_LBA_ADDRESS_TRANSLATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define CHS_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define CHS_ASSERT(lbl, prop, msg)
`define CHS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- hdl/chs_lba_pkg.sv -----
`default_nettype none

package chs_lba_pkg;

    localparam int LBA_BITS   = 28;
    localparam int LBA_W      = 28;
    localparam int CYL_IN_W   = 16;
    localparam int GEO_W      = 8;
    localparam int HPC_W      = GEO_W + 1;
    localparam int REM_W      = GEO_W + 1;
    localparam int OUT_LBA_W  = 32;
    localparam int DIV_BPS    = 4;
    localparam int DIV_STAGES = (LBA_W + DIV_BPS - 1) / DIV_BPS;
    localparam int PIPE_STAGES = 2 * DIV_STAGES;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [LBA_W-1:0] LBA_MASK = LBA_W'((33'd1 << LBA_BITS) - 33'd1);

    localparam logic [GEO_W-1:0] SPT_RESET  = GEO_W'(63);
    localparam logic [GEO_W-1:0] HEAD_RESET = GEO_W'(15);

    localparam logic KIND_CHS2LBA = 1'b0;
    localparam logic KIND_LBA2CHS = 1'b1;

    localparam logic REG_SPT  = 1'b0;
    localparam logic REG_HEAD = 1'b1;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [LBA_W-1:0] work;
    } div_st_t;

    typedef struct packed {
        logic [CYL_IN_W-1:0]  cyl;
        logic [OUT_LBA_W-1:0] sm1;
        logic [15:0]          hd;
        logic [16:0]          hs;
    } k0a_t;

    typedef struct packed {
        logic [OUT_LBA_W-1:0] part;
        logic [OUT_LBA_W-1:0] cp;
    } k0b_t;

    typedef struct packed {
        logic                 kind;
        logic [OUT_LBA_W-1:0] lba;
        logic [GEO_W-1:0]     sec;
    } side_t;

    function automatic div_st_t div_steps(
        input logic [REM_W-1:0] rem,
        input logic [LBA_W-1:0] work,
        input logic [REM_W-1:0] dvs,
        input int               first
    );
        logic [REM_W:0] trial;
        div_st_t        st;
        st.rem  = rem;
        st.work = work;
        for (int j = 0; j < DIV_BPS; j++) begin
            if (first + j < LBA_W) begin
                trial   = {st.rem, st.work[LBA_W-1]};
                st.work = {st.work[LBA_W-2:0], 1'b0};
                if (trial >= {1'b0, dvs}) begin
                    trial      = trial - {1'b0, dvs};
                    st.work[0] = 1'b1;
                end
                st.rem = trial[REM_W-1:0];
            end
        end
        return st;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/chs_lba_div.sv -----
`default_nettype none

module chs_lba_div import chs_lba_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic [DIV_STAGES-1:0] stage_en,
    input  wire logic [LBA_W-1:0]      dividend,
    input  wire logic [REM_W-1:0]      divisor,
    output logic      [LBA_W-1:0]      quotient,
    output logic      [REM_W-1:0]      remainder
);

    div_st_t st_reg  [DIV_STAGES];
    div_st_t st_next [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb begin
                st_next[s] = div_steps('0, dividend, divisor, 0);
            end
        end else begin : g_rest
            always_comb begin
                st_next[s] = div_steps(st_reg[s-1].rem, st_reg[s-1].work, divisor,
                                       s * DIV_BPS);
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_en[s]) begin
                st_reg[s] <= st_next[s];
            end
        end
    end

    assign quotient  = st_reg[DIV_STAGES-1].work;
    assign remainder = st_reg[DIV_STAGES-1].rem;

endmodule

`default_nettype wire

// ----- hdl/chs_lba_address_translator_unit.sv -----
// CHS / LBA address translator.
// Request channel s_*: s_kind selects CHS to LBA (s_in_cylinder, s_in_head,
// s_in_sector) or LBA to CHS (s_in_lba). Result channel m_*: one result per
// request, in order; fields not produced by the selected kind read zero.
// Geometry comes from two APB registers: sectors per track at 0x0 and the
// head register (heads per cylinder minus one) at 0x4. Write them only while
// no request is in flight.
// Each request passes through the two 7-stage restoring dividers (4 quotient
// bits per stage; the first stage loads at the accept edge) and then the
// output register.
// Throughput: one request per cycle while s_ready is high.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// registers with 63 sectors per track and 15 for the head register.
// When the receiver holds m_ready low the result stays on m_*, empty stages
// behind it keep filling, and s_ready drops only once every stage is full.
`default_nettype none

`include "chs_lba_address_translator_unit_assert.svh"

module chs_lba_address_translator_unit import chs_lba_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic [CYL_IN_W-1:0]   s_in_cylinder,
    input  wire logic [GEO_W-1:0]      s_in_head,
    input  wire logic [GEO_W-1:0]      s_in_sector,
    input  wire logic [LBA_W-1:0]      s_in_lba,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [OUT_LBA_W-1:0]  m_out_lba,
    output logic      [LBA_W-1:0]      m_out_cylinder,
    output logic      [GEO_W-1:0]      m_out_head,
    output logic      [GEO_W-1:0]      m_out_sector
);

    logic [GEO_W-1:0] spt_reg;
    logic [GEO_W-1:0] head_reg;
    logic [HPC_W-1:0] hpc;
    logic             cfg_wr;

    logic [PIPE_STAGES-1:0] v_reg;
    logic [PIPE_STAGES-1:0] v_next;
    logic [PIPE_STAGES:0]   rdy;
    logic                   out_ready;

    k0a_t  k0a_reg;
    k0a_t  k0a_next;
    k0b_t  k0b_reg;
    k0b_t  k0b_next;
    side_t side_reg  [PIPE_STAGES];
    side_t side_next [PIPE_STAGES];

    logic [LBA_W-1:0] d1_quo;
    logic [REM_W-1:0] d1_rem;
    logic [LBA_W-1:0] d2_quo;
    logic [REM_W-1:0] d2_rem;

    logic                 m_valid_reg;
    logic [OUT_LBA_W-1:0] out_lba_reg;
    logic [OUT_LBA_W-1:0] out_lba_next;
    logic [LBA_W-1:0]     out_cyl_reg;
    logic [LBA_W-1:0]     out_cyl_next;
    logic [GEO_W-1:0]     out_head_reg;
    logic [GEO_W-1:0]     out_head_next;
    logic [GEO_W-1:0]     out_sec_reg;
    logic [GEO_W-1:0]     out_sec_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg  <= SPT_RESET;
            head_reg <= HEAD_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_SPT:  spt_reg  <= pwdata[GEO_W-1:0];
                REG_HEAD: head_reg <= pwdata[GEO_W-1:0];
                default:  spt_reg  <= spt_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SPT:  prdata = APB_DW'(spt_reg);
            REG_HEAD: prdata = APB_DW'(head_reg);
            default:  prdata = '0;
        endcase
    end

    assign hpc = HPC_W'(head_reg) + HPC_W'(1);

    // stage flow control
    assign out_ready        = !m_valid_reg || m_ready;
    assign rdy[PIPE_STAGES] = out_ready;

    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_flow
        assign rdy[k] = !v_reg[k] || rdy[k+1];
        if (k == 0) begin : g_head
            assign v_next[k] = rdy[k] ? s_valid : v_reg[k];
        end else begin : g_body
            assign v_next[k] = rdy[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    assign s_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
            if (out_ready) begin
                m_valid_reg <= v_reg[PIPE_STAGES-1];
            end
        end
    end

    // CHS to LBA arithmetic
    always_comb begin
        k0a_next.cyl = s_in_cylinder;
        k0a_next.sm1 = OUT_LBA_W'(s_in_sector) - OUT_LBA_W'(1);
        k0a_next.hd  = 16'(s_in_head) * 16'(spt_reg);
        k0a_next.hs  = 17'(hpc) * 17'(spt_reg);
        k0b_next.part = k0a_reg.sm1 + OUT_LBA_W'(k0a_reg.hd);
        k0b_next.cp   = OUT_LBA_W'(33'(k0a_reg.cyl) * 33'(k0a_reg.hs));
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            k0a_reg <= k0a_next;
        end
        if (rdy[1]) begin
            k0b_reg <= k0b_next;
        end
    end

    // sideband carried next to the dividers
    for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_side
        if (k == 0) begin : g_head
            always_comb begin
                side_next[k].kind = s_kind;
                side_next[k].lba  = '0;
                side_next[k].sec  = '0;
            end
        end else begin : g_body
            always_comb begin
                side_next[k] = side_reg[k-1];
                if (k == 2) begin
                    side_next[k].lba = k0b_reg.part + k0b_reg.cp;
                end
                if (k == DIV_STAGES) begin
                    side_next[k].sec = d1_rem[GEO_W-1:0] + GEO_W'(1);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    // LBA to CHS: divide by sectors per track, then by heads per cylinder
    chs_lba_div u_div_spt (
        .aclk      (aclk),
        .stage_en  (rdy[0 +: DIV_STAGES]),
        .dividend  (s_in_lba & LBA_MASK),
        .divisor   (REM_W'(spt_reg)),
        .quotient  (d1_quo),
        .remainder (d1_rem)
    );

    chs_lba_div u_div_hpc (
        .aclk      (aclk),
        .stage_en  (rdy[DIV_STAGES +: DIV_STAGES]),
        .dividend  (d1_quo),
        .divisor   (REM_W'(hpc)),
        .quotient  (d2_quo),
        .remainder (d2_rem)
    );

    // output register
    always_comb begin
        out_lba_next  = '0;
        out_cyl_next  = '0;
        out_head_next = '0;
        out_sec_next  = '0;
        priority if (side_reg[PIPE_STAGES-1].kind == KIND_CHS2LBA) begin
            out_lba_next = side_reg[PIPE_STAGES-1].lba;
        end else if (side_reg[PIPE_STAGES-1].kind == KIND_LBA2CHS && spt_reg != '0) begin
            out_cyl_next  = d2_quo;
            out_head_next = d2_rem[GEO_W-1:0];
            out_sec_next  = side_reg[PIPE_STAGES-1].sec;
        end else begin
            out_lba_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready) begin
            out_lba_reg  <= out_lba_next;
            out_cyl_reg  <= out_cyl_next;
            out_head_reg <= out_head_next;
            out_sec_reg  <= out_sec_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_lba      = out_lba_reg;
    assign m_out_cylinder = out_cyl_reg;
    assign m_out_head     = out_head_reg;
    assign m_out_sector   = out_sec_reg;

    `CHS_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid && v_reg == '0, "pipeline not empty after reset")
    `CHS_ASSERT(a_kind_exclusive, m_valid && m_out_lba != '0 |-> m_out_cylinder == '0 && m_out_head == '0 && m_out_sector == '0, "both result kinds populated")
    `CHS_ASSERT(a_head_range, m_valid |-> m_out_head <= head_reg, "head beyond geometry")
    `CHS_ASSERT(a_sector_range, m_valid |-> m_out_sector <= spt_reg, "sector beyond geometry")
    `CHS_ASSERT(a_rem_range, v_reg[DIV_STAGES-1] && spt_reg != '0 |-> d1_rem < REM_W'(spt_reg), "remainder not below divisor")

endmodule

`default_nettype wire
